/* hw/rtl/blcg_pkg.sv */
// ----------------------------------------------------------------------------
// blcg_pkg
// Shared widths, register indexes and the raised-cosine table function of the
// breathing LED color generator.
// ----------------------------------------------------------------------------
package blcg_pkg;

    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int COLOR_W  = 8;
    localparam int PCT_W    = 7;
    localparam int WAVE_W   = 16;
    localparam int CFG_W    = 16;
    localparam int REG_IDX_W = 3;

    localparam int WAVE_TABLE_DEPTH = 256;
    localparam int IDX_W = $clog2(WAVE_TABLE_DEPTH);

    // wave * pct and base * wave * pct
    localparam int WP_W   = WAVE_W + PCT_W;
    localparam int PROD_W = WP_W + COLOR_W;

    // Full scale of the wave times full scale of the percentage.
    localparam longint unsigned SCALE_DIV = 64'd65535 * 64'd100;

    localparam logic [PCT_W-1:0]   PCT_MAX    = 7'd100;
    localparam logic [COLOR_W-1:0] LAST_RESET = 8'd255;

    localparam longint unsigned PI_Q28    = 64'd843314857;
    localparam int              FRAC_BITS = 28;

    localparam logic [REG_IDX_W-1:0] REG_PERIOD     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BASE_RED   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BASE_GREEN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BASE_BLUE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE     = 3'd5;

    // Truncating quotient by shift and subtract, used while the table is
    // built. The divisor stays far below 2^63, so the remainder never wraps.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned part;
        q    = 0;
        part = 0;
        for (int b = 63; b >= 0; b--) begin
            part = {part[62:0], num[b]};
            if (part >= den) begin
                part = part - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Raised cosine (1 - cos(2*pi*i/D)) / 2 in Q0.16, built from a Taylor
    // series of cos in Q4.28. Evaluated only at elaboration.
    function automatic logic [WAVE_W-1:0] wave_value(input int unsigned i);
        longint unsigned j;
        longint unsigned x;
        longint unsigned y;
        longint unsigned term;
        longint unsigned v;
        longint          sum;
        longint unsigned k;
        if (2 * i <= WAVE_TABLE_DEPTH) begin
            j = longint'(i);
        end else begin
            j = longint'(WAVE_TABLE_DEPTH - i);
        end
        x    = (PI_Q28 * 2 * j + WAVE_TABLE_DEPTH / 2) / WAVE_TABLE_DEPTH;
        y    = (x * x) >> FRAC_BITS;
        term = y >> 1;
        sum  = 0;
        for (k = 1; k < 64 && term != 0; k++) begin
            if (k[0]) begin
                sum = sum + longint'(term);
            end else begin
                sum = sum - longint'(term);
            end
            term = udiv64((term * y) >> FRAC_BITS, (2 * k + 1) * (2 * k + 2));
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (longint'(sum) * 65535 + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
        if (v > 65535) begin
            v = 65535;
        end
        return v[WAVE_W-1:0];
    endfunction

endpackage

/* hw/rtl/blcg_phase_div.sv */
// ----------------------------------------------------------------------------
// blcg_phase_div
// Bit-serial restoring divider that reduces the timestamp modulo the period
// and then produces the table index floor(rem * D / period).
// ----------------------------------------------------------------------------
module blcg_phase_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [blcg_pkg::TIME_W-1:0]      i_time,
    input  logic [blcg_pkg::PERIOD_W-1:0]    i_period,
    output logic                             o_done,
    output logic [blcg_pkg::IDX_W-1:0]       o_idx
);

    // The first TIME_W steps leave time mod period in the remainder; the
    // following IDX_W steps shift in zeros, which yields the index bits.
    localparam int STEPS = blcg_pkg::TIME_W + blcg_pkg::IDX_W;
    localparam int CNT_W = $clog2(STEPS);

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [CNT_W-1:0]                r_cnt, n_cnt;
    logic [blcg_pkg::TIME_W-1:0]     r_dvd, n_dvd;
    logic [blcg_pkg::PERIOD_W-1:0]   r_div, n_div;
    logic [blcg_pkg::PERIOD_W-1:0]   r_rem, n_rem;
    logic [blcg_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic [blcg_pkg::PERIOD_W:0]     w_trial;
    logic [blcg_pkg::PERIOD_W:0]     w_diff;
    logic                            w_ge;

    assign w_trial = {r_rem, r_dvd[blcg_pkg::TIME_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_rem  = r_rem;
        n_idx  = r_idx;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_time;
            // A zero period behaves as a period of one.
            n_div  = (i_period == '0) ? blcg_pkg::PERIOD_W'(1) : i_period;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[blcg_pkg::TIME_W-2:0], 1'b0};
            n_rem = w_ge ? w_diff[blcg_pkg::PERIOD_W-1:0]
                         : w_trial[blcg_pkg::PERIOD_W-1:0];
            n_idx = {r_idx[blcg_pkg::IDX_W-2:0], w_ge};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
        r_idx <= n_idx;
    end

    assign o_done = r_done;
    assign o_idx  = r_idx;

endmodule

/* hw/rtl/blcg_scale_lane.sv */
// ----------------------------------------------------------------------------
// blcg_scale_lane
// One color channel: serial shift-add multiply of the base intensity by the
// scaled wave, then a serial division by the constant full scale.
// ----------------------------------------------------------------------------
module blcg_scale_lane (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [blcg_pkg::COLOR_W-1:0]   i_base,
    input  logic [blcg_pkg::WP_W-1:0]      i_wp,
    output logic                           o_done,
    output logic [blcg_pkg::COLOR_W-1:0]   o_value
);

    localparam int STEPS = 2 * blcg_pkg::COLOR_W;
    localparam int CNT_W = $clog2(STEPS);
    // The quotient fits in COLOR_W bits, so the divisor starts at its top
    // quotient weight and moves right one place per step.
    localparam logic [blcg_pkg::PROD_W-1:0] CMP_INIT =
        blcg_pkg::PROD_W'(blcg_pkg::SCALE_DIV) << (blcg_pkg::COLOR_W - 1);

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [CNT_W-1:0]                r_cnt, n_cnt;
    logic [blcg_pkg::COLOR_W-1:0]    r_base, n_base;
    logic [blcg_pkg::WP_W-1:0]       r_wp, n_wp;
    logic [blcg_pkg::PROD_W-1:0]     r_acc, n_acc;
    logic [blcg_pkg::PROD_W-1:0]     r_cmp, n_cmp;
    logic [blcg_pkg::COLOR_W-1:0]    r_q, n_q;
    logic                            w_ge;

    assign w_ge = r_acc >= r_cmp;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_base = r_base;
        n_wp   = r_wp;
        n_acc  = r_acc;
        n_cmp  = r_cmp;
        n_q    = r_q;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_base = i_base;
            n_wp   = i_wp;
            n_acc  = '0;
            n_cmp  = CMP_INIT;
            n_q    = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt < CNT_W'(blcg_pkg::COLOR_W)) begin
                // Multiply, most significant base bit first.
                n_acc  = {r_acc[blcg_pkg::PROD_W-2:0], 1'b0}
                       + (r_base[blcg_pkg::COLOR_W-1] ? blcg_pkg::PROD_W'(r_wp) : '0);
                n_base = {r_base[blcg_pkg::COLOR_W-2:0], 1'b0};
            end else begin
                n_acc = w_ge ? (r_acc - r_cmp) : r_acc;
                n_q   = {r_q[blcg_pkg::COLOR_W-2:0], w_ge};
                n_cmp = r_cmp >> 1;
            end
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_base <= n_base;
        r_wp   <= n_wp;
        r_acc  <= n_acc;
        r_cmp  <= n_cmp;
        r_q    <= n_q;
    end

    assign o_done  = r_done;
    assign o_value = r_q;

endmodule

/* hw/rtl/breathing_led_color_generator_top.sv */
// ----------------------------------------------------------------------------
// breathing_led_color_generator_top
// Turns millisecond ticks into a breathing RGB color and reports changes.
// ----------------------------------------------------------------------------
// Usage:
// A tick transfers on the time channel (i_time_valid / o_time_ready). The
// block takes one tick at a time: the timestamp runs through a bit-serial
// divider, a table lookup, a serial multiply by the brightness and three
// parallel channel lanes that multiply and divide one bit per cycle. Each
// hand-off is registered and the color is loaded into an output register.
// The next tick is taken once that color is loaded or found unchanged; a
// tick taken while output is disabled leaves the block idle for the next.
// A color transfers on the color channel (o_color_valid / i_color_ready) only
// when it differs from the last color produced; with output disabled, ticks
// are taken and dropped. The color sits in an output register, so a stalled
// receiver does not stop the next tick from being taken; only a second
// changed color waits until that register is free.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while the
// block is idle, a rule for the user that the block itself does not enforce.
// A brightness write forces the next color out unless it is 255,255,255.
// Reset (synchronous, active low) restores the register defaults and
// returns the block to idle with an empty output register.
// ----------------------------------------------------------------------------
module breathing_led_color_generator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [blcg_pkg::REG_IDX_W-1:0]      i_cfg_idx,
    input  logic [blcg_pkg::CFG_W-1:0]          i_cfg_data,
    // ticks
    input  logic                                i_time_valid,
    output logic                                o_time_ready,
    input  logic [blcg_pkg::TIME_W-1:0]         i_time_ms,
    // colors
    output logic                                o_color_valid,
    input  logic                                i_color_ready,
    output logic [blcg_pkg::COLOR_W-1:0]        o_red,
    output logic [blcg_pkg::COLOR_W-1:0]        o_green,
    output logic [blcg_pkg::COLOR_W-1:0]        o_blue
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_LOOK  = 6'b000100,
        ST_WPMUL = 6'b001000,
        ST_SCALE = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    localparam int WP_CNT_W = $clog2(blcg_pkg::PCT_W);

    // Raised-cosine table, filled at elaboration.
    logic [blcg_pkg::WAVE_W-1:0] w_wave [blcg_pkg::WAVE_TABLE_DEPTH];

    for (genvar g = 0; g < blcg_pkg::WAVE_TABLE_DEPTH; g++) begin : g_wave
        localparam logic [blcg_pkg::WAVE_W-1:0] WaveVal = blcg_pkg::wave_value(g);
        assign w_wave[g] = WaveVal;
    end

    t_state                           r_state, n_state;
    logic [blcg_pkg::PERIOD_W-1:0]    r_period;
    logic [blcg_pkg::COLOR_W-1:0]     r_base_red, r_base_green, r_base_blue;
    logic [blcg_pkg::PCT_W-1:0]       r_pct;
    logic                             r_enable;
    logic [blcg_pkg::COLOR_W-1:0]     r_last_red, r_last_green, r_last_blue;
    logic [blcg_pkg::WAVE_W-1:0]      r_wave, n_wave;
    logic [blcg_pkg::WP_W-1:0]        r_wp, n_wp;
    logic [blcg_pkg::PCT_W-1:0]       r_pct_sh, n_pct_sh;
    logic [WP_CNT_W-1:0]              r_cnt, n_cnt;
    logic                             r_lane_start, n_lane_start;
    logic                             r_out_valid;
    logic [blcg_pkg::COLOR_W-1:0]     r_out_red, r_out_green, r_out_blue;

    logic                             w_accept;
    logic                             w_div_start;
    logic                             w_div_done;
    logic [blcg_pkg::IDX_W-1:0]       w_idx;
    logic                             w_red_done, w_green_done, w_blue_done;
    logic [blcg_pkg::COLOR_W-1:0]     w_red, w_green, w_blue;
    logic                             w_changed;
    logic                             w_load;
    logic [blcg_pkg::PCT_W-1:0]       w_pct_wr;

    assign o_time_ready = r_state == ST_IDLE;
    assign w_accept     = i_time_valid && o_time_ready;
    assign w_div_start  = w_accept && r_enable;

    blcg_phase_div u_phase_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_time   (i_time_ms),
        .i_period (r_period),
        .o_done   (w_div_done),
        .o_idx    (w_idx)
    );

    blcg_scale_lane u_lane_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_lane_start),
        .i_base  (r_base_red),
        .i_wp    (r_wp),
        .o_done  (w_red_done),
        .o_value (w_red)
    );

    blcg_scale_lane u_lane_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_lane_start),
        .i_base  (r_base_green),
        .i_wp    (r_wp),
        .o_done  (w_green_done),
        .o_value (w_green)
    );

    blcg_scale_lane u_lane_blue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_lane_start),
        .i_base  (r_base_blue),
        .i_wp    (r_wp),
        .o_done  (w_blue_done),
        .o_value (w_blue)
    );

    assign w_changed = (w_red != r_last_red) || (w_green != r_last_green)
                    || (w_blue != r_last_blue);
    assign w_load    = (r_state == ST_EMIT) && w_changed
                    && (!r_out_valid || i_color_ready);

    always_comb begin
        n_state      = r_state;
        n_wave       = r_wave;
        n_wp         = r_wp;
        n_pct_sh     = r_pct_sh;
        n_cnt        = r_cnt;
        n_lane_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_div_start) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_wave   = w_wave[w_idx];
                n_wp     = '0;
                n_pct_sh = r_pct;
                n_cnt    = '0;
                n_state  = ST_WPMUL;
            end
            ST_WPMUL: begin
                // wave * pct, one percentage bit per cycle.
                n_wp     = {r_wp[blcg_pkg::WP_W-2:0], 1'b0}
                         + (r_pct_sh[blcg_pkg::PCT_W-1] ? blcg_pkg::WP_W'(r_wave) : '0);
                n_pct_sh = {r_pct_sh[blcg_pkg::PCT_W-2:0], 1'b0};
                n_cnt    = r_cnt + WP_CNT_W'(1);
                if (r_cnt == WP_CNT_W'(blcg_pkg::PCT_W - 1)) begin
                    n_lane_start = 1'b1;
                    n_state      = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (w_red_done && w_green_done && w_blue_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!w_changed || w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_pct_wr = (i_cfg_data[blcg_pkg::PCT_W-1:0] > blcg_pkg::PCT_MAX)
                    ? blcg_pkg::PCT_MAX : i_cfg_data[blcg_pkg::PCT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_lane_start <= 1'b0;
            r_out_valid  <= 1'b0;
            r_period     <= 16'd8000;
            r_base_red   <= 8'd20;
            r_base_green <= 8'd20;
            r_base_blue  <= 8'd40;
            r_pct        <= blcg_pkg::PCT_MAX;
            r_enable     <= 1'b1;
            r_last_red   <= blcg_pkg::LAST_RESET;
            r_last_green <= blcg_pkg::LAST_RESET;
            r_last_blue  <= blcg_pkg::LAST_RESET;
        end else begin
            r_state      <= n_state;
            r_lane_start <= n_lane_start;
            if (w_load) begin
                r_out_valid  <= 1'b1;
                r_last_red   <= w_red;
                r_last_green <= w_green;
                r_last_blue  <= w_blue;
            end else if (i_color_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    blcg_pkg::REG_PERIOD: begin
                        r_period <= i_cfg_data;
                    end
                    blcg_pkg::REG_BASE_RED: begin
                        r_base_red <= i_cfg_data[blcg_pkg::COLOR_W-1:0];
                    end
                    blcg_pkg::REG_BASE_GREEN: begin
                        r_base_green <= i_cfg_data[blcg_pkg::COLOR_W-1:0];
                    end
                    blcg_pkg::REG_BASE_BLUE: begin
                        r_base_blue <= i_cfg_data[blcg_pkg::COLOR_W-1:0];
                    end
                    blcg_pkg::REG_BRIGHTNESS: begin
                        // Any brightness write forces the next color out, unless it is 255,255,255.
                        r_pct        <= w_pct_wr;
                        r_last_red   <= blcg_pkg::LAST_RESET;
                        r_last_green <= blcg_pkg::LAST_RESET;
                        r_last_blue  <= blcg_pkg::LAST_RESET;
                    end
                    blcg_pkg::REG_ENABLE: begin
                        r_enable <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        r_wave   <= n_wave;
        r_wp     <= n_wp;
        r_pct_sh <= n_pct_sh;
        r_cnt    <= n_cnt;
        if (w_load) begin
            r_out_red   <= w_red;
            r_out_green <= w_green;
            r_out_blue  <= w_blue;
        end
    end

    assign o_color_valid = r_out_valid;
    assign o_red         = r_out_red;
    assign o_green       = r_out_green;
    assign o_blue        = r_out_blue;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Breathing LED color generator testbench
// Sends millisecond ticks over the time channel and checks every color the
// block reports against a local prediction of the raised-cosine breathing
// color. A directed sequence covers the corner cases of the registers and
// timestamps. Random traffic follows under three pacing modes, with
// register changes while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

    localparam int COLOR_W   = blcg_pkg::COLOR_W;
    localparam int REG_IDX_W = blcg_pkg::REG_IDX_W;
    localparam int CFG_W     = blcg_pkg::CFG_W;
    localparam int TIME_W    = blcg_pkg::TIME_W;
    localparam int PERIOD_W  = blcg_pkg::PERIOD_W;
    localparam int PCT_W     = blcg_pkg::PCT_W;
    localparam int WAVE_W    = blcg_pkg::WAVE_W;
    localparam int IDX_W     = blcg_pkg::IDX_W;
    localparam int FRAC_BITS = blcg_pkg::FRAC_BITS;
    localparam longint unsigned PI_Q28    = blcg_pkg::PI_Q28;
    localparam longint unsigned SCALE_DIV = blcg_pkg::SCALE_DIV;
    localparam logic [PCT_W-1:0]   PCT_MAX    = blcg_pkg::PCT_MAX;
    localparam logic [COLOR_W-1:0] LAST_RESET = blcg_pkg::LAST_RESET;

    localparam logic [REG_IDX_W-1:0] REG_PERIOD     = blcg_pkg::REG_PERIOD;
    localparam logic [REG_IDX_W-1:0] REG_BASE_RED   = blcg_pkg::REG_BASE_RED;
    localparam logic [REG_IDX_W-1:0] REG_BASE_GREEN = blcg_pkg::REG_BASE_GREEN;
    localparam logic [REG_IDX_W-1:0] REG_BASE_BLUE  = blcg_pkg::REG_BASE_BLUE;
    localparam logic [REG_IDX_W-1:0] REG_BRIGHTNESS = blcg_pkg::REG_BRIGHTNESS;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE     = blcg_pkg::REG_ENABLE;

    typedef longint unsigned t_u64;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_color;

    typedef enum logic [0:0] {ROW_TICK, ROW_WRITE} t_row_kind;
    typedef enum logic [1:0] {CHK_PREDICT, CHK_COLOR, CHK_SILENT} t_row_check;

    typedef struct packed {
        t_row_kind              kind;
        logic [REG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       value;
        logic [TIME_W-1:0]      stamp;
        t_row_check             how;
        t_color                 hue;
    } t_row;

    localparam int DEPTH = blcg_pkg::WAVE_TABLE_DEPTH;

    // Indexes past the register list; writes there must be ignored.
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [REG_IDX_W-1:0] UNUSED_IDX   = REG_PERIOD;

    localparam logic [REG_IDX_W-1:0] REG_ORDER [8] = '{
        REG_PERIOD, REG_BASE_RED, REG_BASE_GREEN, REG_BASE_BLUE,
        REG_BRIGHTNESS, REG_ENABLE, REG_SPARE_LO, REG_SPARE_HI
    };

    localparam t_color ANY          = '0;
    localparam t_color BLACK        = '{8'd0, 8'd0, 8'd0};
    localparam t_color DEFAULT_PEAK = '{8'd20, 8'd20, 8'd40};
    localparam t_color HALF_PEAK    = '{8'd0, 8'd64, 8'd127};

    localparam int NUM_ROWS = 37;
    localparam t_row DIRECTED [NUM_ROWS] = '{
        // Register defaults right after reset.
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd0,          CHK_COLOR,   BLACK},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd4000,       CHK_COLOR,   DEFAULT_PEAK},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd8000,       CHK_COLOR,   BLACK},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd8000,       CHK_SILENT,  ANY},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'hFFFF_FFFF,  CHK_PREDICT, ANY},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd2000,       CHK_PREDICT, ANY},
        // A zero period behaves as one millisecond.
        '{ROW_WRITE, REG_PERIOD,     16'h0000, 32'd0,          CHK_PREDICT, ANY},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd12345,      CHK_COLOR,   BLACK},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'hFFFF_FFFF,  CHK_SILENT,  ANY},
        // Full scale colors; the upper data bits must be masked off.
        '{ROW_WRITE, REG_PERIOD,     16'hFFFF, 32'd0,          CHK_PREDICT, ANY},
        '{ROW_WRITE, REG_BASE_RED,   16'hA5FF, 32'd0,          CHK_PREDICT, ANY},
        '{ROW_WRITE, REG_BASE_GREEN, 16'h00FF, 32'd0,          CHK_PREDICT, ANY},
        '{ROW_WRITE, REG_BASE_BLUE,  16'hFFFF, 32'd0,          CHK_PREDICT, ANY},
        '{ROW_WRITE, REG_BRIGHTNESS, 16'h007F, 32'd0,          CHK_PREDICT, ANY},
        // White right after a forced redraw matches the reset color.
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd32768,      CHK_SILENT,  ANY},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd65534,      CHK_PREDICT, ANY},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd65535,      CHK_SILENT,  ANY},
        '{ROW_WRITE, REG_BRIGHTNESS, 16'hFF80, 32'd0,          CHK_PREDICT, ANY},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd32768,      CHK_COLOR,   BLACK},
        '{ROW_WRITE, REG_BRIGHTNESS, 16'd50,   32'd0,          CHK_PREDICT, ANY},
        '{ROW_WRITE, REG_BASE_RED,   16'h5A00, 32'd0,          CHK_PREDICT, ANY},
        '{ROW_WRITE, REG_BASE_GREEN, 16'd128,  32'd0,          CHK_PREDICT, ANY},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd32768,      CHK_COLOR,   HALF_PEAK},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd16384,      CHK_PREDICT, ANY},
        // Output disabled: ticks are taken and dropped.
        '{ROW_WRITE, REG_ENABLE,     16'hFFFE, 32'd0,          CHK_PREDICT, ANY},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd0,          CHK_SILENT,  ANY},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd40000,      CHK_SILENT,  ANY},
        '{ROW_WRITE, REG_SPARE_LO,   16'hFFFF, 32'd0,          CHK_PREDICT, ANY},
        '{ROW_WRITE, REG_SPARE_HI,   16'h0000, 32'd0,          CHK_PREDICT, ANY},
        '{ROW_WRITE, REG_ENABLE,     16'h0001, 32'd0,          CHK_PREDICT, ANY},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd0,          CHK_COLOR,   BLACK},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd1,          CHK_SILENT,  ANY},
        '{ROW_WRITE, REG_PERIOD,     16'd1,    32'd0,          CHK_PREDICT, ANY},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd7,          CHK_SILENT,  ANY},
        '{ROW_WRITE, REG_PERIOD,     16'd2,    32'd0,          CHK_PREDICT, ANY},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'd1,          CHK_COLOR,   HALF_PEAK},
        '{ROW_TICK,  UNUSED_IDX,     16'h0000, 32'h8000_0000,  CHK_COLOR,   BLACK}
    };

    localparam int unsigned SEND_IDLE  [3] = '{6, 58, 0};
    localparam int unsigned RECV_STALL [3] = '{58, 6, 0};
    localparam int unsigned SEGMENTS      = 8;
    localparam int unsigned SEGMENT_TICKS = 39;
    localparam int unsigned SETTLE_CYCLES = 100;
    localparam int unsigned STALL_LIMIT   = 5000;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [REG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_W-1:0]      i_cfg_data    = '0;
    logic                  i_time_valid  = 1'b0;
    logic                  o_time_ready;
    logic [TIME_W-1:0]     i_time_ms     = '0;
    logic                  o_color_valid;
    logic                  i_color_ready = 1'b0;
    logic [COLOR_W-1:0]    o_red;
    logic [COLOR_W-1:0]    o_green;
    logic [COLOR_W-1:0]    o_blue;

    // Predicted register contents and the last color reported.
    logic [PERIOD_W-1:0]   cfg_period;
    logic [COLOR_W-1:0]    cfg_red;
    logic [COLOR_W-1:0]    cfg_green;
    logic [COLOR_W-1:0]    cfg_blue;
    logic [PCT_W-1:0]      cfg_pct;
    logic                  cfg_on;
    t_color                shown_color;

    logic [WAVE_W-1:0]     wave_lut [DEPTH];
    t_color                pending_colors [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches     = 0;
    int unsigned colors_checked = 0;
    int unsigned ticks_sent     = 0;
    int unsigned cfg_writes     = 0;
    int unsigned quiet_cycles   = 0;
    logic [TIME_W-1:0] clock_ms = '0;
    bit tick_live = 1'b0;

    breathing_led_color_generator_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_time_valid  (i_time_valid),
        .o_time_ready  (o_time_ready),
        .i_time_ms     (i_time_ms),
        .o_color_valid (o_color_valid),
        .i_color_ready (i_color_ready),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // (1 - cos(2*pi*slot/DEPTH)) / 2 in Q0.16, from a cosine series in Q4.28.
    function automatic logic [WAVE_W-1:0] raised_cosine(input int unsigned slot);
        t_u64        fold;
        t_u64        angle;
        t_u64        sq;
        t_u64        term;
        t_u64        level;
        longint      acc;
        int unsigned n;
        fold  = (2 * slot <= DEPTH) ? t_u64'(slot) : t_u64'(DEPTH - slot);
        angle = (PI_Q28 * 2 * fold + DEPTH / 2) / DEPTH;
        sq    = (angle * angle) >> FRAC_BITS;
        term  = sq >> 1;
        acc   = 0;
        n     = 1;
        while (term != 0 && n < 64) begin
            if (n[0]) begin
                acc = acc + longint'(term);
            end else begin
                acc = acc - longint'(term);
            end
            term = ((term * sq) >> FRAC_BITS) / t_u64'((2 * n + 1) * (2 * n + 2));
            n++;
        end
        if (acc < 0) begin
            acc = 0;
        end
        level = (t_u64'(acc) * 65535 + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
        return (level > 65535) ? 16'hFFFF : level[WAVE_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] dim(input logic [COLOR_W-1:0] base,
                                               input logic [WAVE_W-1:0] level);
        t_u64 prod;
        prod = t_u64'(base) * t_u64'(level) * t_u64'(cfg_pct);
        return 8'(prod / SCALE_DIV);
    endfunction

    // Returns 1 when the tick makes the block report a new color.
    function automatic bit next_color(input logic [TIME_W-1:0] stamp, output t_color hue);
        t_u64              span;
        t_u64              slot;
        logic [WAVE_W-1:0] level;
        span  = (cfg_period == '0) ? 64'd1 : t_u64'(cfg_period);
        slot  = ((t_u64'(stamp) % span) * DEPTH) / span;
        level = wave_lut[slot[IDX_W-1:0]];
        hue.red   = dim(cfg_red, level);
        hue.green = dim(cfg_green, level);
        hue.blue  = dim(cfg_blue, level);
        if (!cfg_on || hue == shown_color) begin
            return 1'b0;
        end
        shown_color = hue;
        return 1'b1;
    endfunction

    function automatic void note_write(input logic [REG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] value);
        case (idx)
            REG_PERIOD:     cfg_period = value[PERIOD_W-1:0];
            REG_BASE_RED:   cfg_red    = value[COLOR_W-1:0];
            REG_BASE_GREEN: cfg_green  = value[COLOR_W-1:0];
            REG_BASE_BLUE:  cfg_blue   = value[COLOR_W-1:0];
            REG_BRIGHTNESS: begin
                cfg_pct     = (value[PCT_W-1:0] > PCT_MAX) ? PCT_MAX : value[PCT_W-1:0];
                shown_color = '{LAST_RESET, LAST_RESET, LAST_RESET};
            end
            REG_ENABLE:     cfg_on     = value[0];
            default:        ;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] cfg_value(input logic [REG_IDX_W-1:0] idx);
        logic [CFG_W-1:0] junk;
        logic [7:0]       pick;
        junk = CFG_W'($urandom);
        case ($urandom_range(3))
            0:       pick = 8'd0;
            1:       pick = 8'hFF;
            default: pick = 8'($urandom);
        endcase
        case (idx)
            REG_PERIOD: begin
                case ($urandom_range(6))
                    0:       return 16'd0;
                    1:       return 16'd1;
                    2:       return 16'hFFFF;
                    3:       return 16'($urandom_range(2, 300));
                    4, 5:    return 16'($urandom_range(300, 9000));
                    default: return junk;
                endcase
            end
            REG_BASE_RED, REG_BASE_GREEN, REG_BASE_BLUE: begin
                return {junk[CFG_W-1:COLOR_W], pick};
            end
            REG_BRIGHTNESS: begin
                case ($urandom_range(4))
                    0:       return {junk[CFG_W-1:PCT_W], 7'd0};
                    1:       return {junk[CFG_W-1:PCT_W], PCT_MAX};
                    2:       return {junk[CFG_W-1:PCT_W], 7'($urandom_range(101, 127))};
                    default: return {junk[CFG_W-1:PCT_W], 7'($urandom_range(0, 100))};
                endcase
            end
            REG_ENABLE: return {junk[CFG_W-1:1], ($urandom_range(9) != 0)};
            default:    return junk;
        endcase
    endfunction

    // Mostly a steadily advancing clock, with jumps and arbitrary stamps mixed in.
    function automatic logic [TIME_W-1:0] pick_time();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70) begin
            clock_ms = clock_ms + $urandom_range(0, (cfg_period >> 5) + 1);
        end else if (roll < 85) begin
            clock_ms = clock_ms + $urandom;
        end else begin
            clock_ms = $urandom;
        end
        return clock_ms;
    endfunction

    function automatic void report(input string why, input string want_text, input t_color got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected %s, got %0d,%0d,%0d",
                     $time, why, want_text, got.red, got.green, got.blue);
        end
    endfunction

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        note_write(idx, value);
        cfg_writes++;
    endtask

    task automatic send_tick(input logic [TIME_W-1:0] stamp, input t_row_check how,
                             input t_color typed);
        t_color hue;
        bit     fresh;
        i_cfg_we <= 1'b0;
        // The sender idles in each cycle with the chance given by the mode.
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_time_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_time_valid <= 1'b1;
        i_time_ms    <= stamp;
        tick_live     = 1'b1;
        do @(posedge i_clk); while (!o_time_ready);
        ticks_sent++;
        fresh = next_color(stamp, hue);
        case (how)
            CHK_PREDICT: begin
                if (fresh) begin
                    pending_colors.push_back(hue);
                end
            end
            CHK_COLOR:   pending_colors.push_back(typed);
            default:     ;
        endcase
    endtask

    // Hold off new ticks until every expected color is out and the block has
    // had time to finish a tick that reports nothing.
    task automatic settle();
        if (tick_live) begin
            i_time_valid <= 1'b0;
            tick_live     = 1'b0;
            while (pending_colors.size() != 0) @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        i_color_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : color_check
        t_color got;
        t_color want;
        if (i_rst_n && o_color_valid && i_color_ready) begin
            got = '{o_red, o_green, o_blue};
            colors_checked++;
            if (pending_colors.size() == 0) begin
                report("color with nothing pending", "no transfer", got);
            end else begin
                want = pending_colors.pop_front();
                if (got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue) begin
                    report("color mismatch",
                           $sformatf("%0d,%0d,%0d", want.red, want.green, want.blue), got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_time_valid && o_time_ready) || (o_color_valid && i_color_ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d colors outstanding",
                     quiet_cycles, pending_colors.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_row row;
        for (int s = 0; s < DEPTH; s++) begin
            wave_lut[s] = raised_cosine(s);
        end
        cfg_period  = 16'd8000;
        cfg_red     = 8'd20;
        cfg_green   = 8'd20;
        cfg_blue    = 8'd40;
        cfg_pct     = PCT_MAX;
        cfg_on      = 1'b1;
        shown_color = '{LAST_RESET, LAST_RESET, LAST_RESET};

        send_idle_pct  = SEND_IDLE[0];
        recv_stall_pct = RECV_STALL[0];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < NUM_ROWS; n++) begin
            row = DIRECTED[n];
            if (row.kind == ROW_WRITE) begin
                settle();
                write_reg(row.idx, row.value);
            end else begin
                send_tick(row.stamp, row.how, row.hue);
            end
        end

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct  = SEND_IDLE[mode];
            recv_stall_pct = RECV_STALL[mode];
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                settle();
                for (int r = 0; r < $size(REG_ORDER); r++) begin
                    if ($urandom_range(99) < 60) begin
                        write_reg(REG_ORDER[r], cfg_value(REG_ORDER[r]));
                    end
                end
                clock_ms = $urandom;
                repeat (SEGMENT_TICKS) send_tick(pick_time(), CHK_PREDICT, ANY);
            end
        end

        settle();
        $display("Sent %0d ticks and %0d register writes under three pacing modes;",
                 ticks_sent, cfg_writes);
        $display("checked %0d colors, %0d mismatches.", colors_checked, mismatches);
        if (mismatches == 0 && pending_colors.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
